@@ hw/rtl/swr_pkg.sv @@
// Shared types, constants and helpers for the streaming word replacer.
package swr_pkg;

  localparam int MAX_WORD    = 16;
  localparam int CNT_W       = $clog2(MAX_WORD + 1);
  localparam int IDX_W       = $clog2(MAX_WORD);
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int CFG_IDX_W   = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_LOW        = 3'd0,
    REG_PATTERN_HIGH       = 3'd1,
    REG_PATTERN_LENGTH     = 3'd2,
    REG_REPLACEMENT_LOW    = 3'd3,
    REG_REPLACEMENT_HIGH   = 3'd4,
    REG_REPLACEMENT_LENGTH = 3'd5
  } reg_idx_t;

  // One command: emit the first count bytes of the vector, in order.
  typedef struct packed {
    logic [MAX_WORD-1:0][7:0] bytes;
    logic [CNT_W-1:0]         count;
    logic                     last;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

  function automatic logic [CNT_W-1:0] clamp_len(input logic [4:0] len);
    logic [CNT_W-1:0] res;
    if (len == 5'd0) begin
      res = CNT_W'(1);
    end else if (len > 5'(MAX_WORD)) begin
      res = CNT_W'(MAX_WORD);
    end else begin
      res = CNT_W'(len);
    end
    return res;
  endfunction

endpackage

@@ hw/rtl/swr_ifs.sv @@
// Handshake interfaces for the text, result and configuration channels.
interface swr_text_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       text_end;
  modport source (output valid, output text_byte, output text_end, input ready);
  modport sink (input valid, input text_byte, input text_end, output ready);
endinterface

interface swr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_end;
  modport source (output valid, output out_byte, output out_end, input ready);
  modport sink (input valid, input out_byte, input out_end, output ready);
endinterface

interface swr_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [63:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

@@ hw/rtl/stream_word_replace.sv @@
// Top level of the streaming find-and-replace block.
//
//   channel  direction  payload                     transaction when
//   text     in         text_byte, text_end         text.valid && text.ready
//   result   out        out_byte, out_end           result.valid && result.ready
//   cfg      in         index, data                 cfg.valid && cfg.ready
//
// A text byte is accepted every cycle while the queue has room and makes at most one
// command; the output register drains one byte per cycle while result is not stalled,
// so the block runs at one byte per cycle unless a command carries several bytes (a
// replacement or the end-of-text flush), which keeps the output busy while the
// four-entry queue absorbs input. Reset is synchronous; there is no clearing pass.
// A stalled result holds its byte; text is refused only when the queue is full.
module stream_word_replace (
  input  logic      clk,
  input  logic      rst,
  swr_text_if.sink  text,
  swr_out_if.source result,
  swr_cfg_if.sink   cfg
);
  import swr_pkg::*;

  cmd_t        wr_cmd;
  cmd_t        head;
  queue_stat_t qstat;
  logic        push;
  logic        pop;

  swr_front u_front (
    .clk   (clk),
    .rst   (rst),
    .text  (text),
    .cfg   (cfg),
    .qstat (qstat),
    .cmd   (wr_cmd),
    .push  (push)
  );

  swr_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr_cmd (wr_cmd),
    .push   (push),
    .pop    (pop),
    .head   (head),
    .qstat  (qstat)
  );

  swr_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .qstat  (qstat),
    .pop    (pop),
    .result (result)
  );

  // The front end must never push into a full queue.
  assert property (@(posedge clk) disable iff (rst) push |-> !qstat.full)
    else $error("command pushed into a full queue");

  // The back end only retires a command that is present.
  assert property (@(posedge clk) disable iff (rst) pop |-> !qstat.empty)
    else $error("command popped from an empty queue");

  // Every queued command carries at least one byte.
  assert property (@(posedge clk) disable iff (rst) !qstat.empty |-> head.count != '0)
    else $error("empty command in queue");

endmodule

@@ hw/rtl/swr_front.sv @@
// Front end: configuration registers, match window and command generation.
module swr_front (
  input  logic               clk,
  input  logic               rst,
  swr_text_if.sink           text,
  swr_cfg_if.sink            cfg,
  input  swr_pkg::queue_stat_t qstat,
  output swr_pkg::cmd_t      cmd,
  output logic               push
);
  import swr_pkg::*;

  logic [63:0]              pattern_low;
  logic [63:0]              pattern_high;
  logic [4:0]               pattern_length;
  logic [63:0]              replacement_low;
  logic [63:0]              replacement_high;
  logic [4:0]               replacement_length;
  logic [MAX_WORD-1:0][7:0] window;
  logic [MAX_WORD-1:0][7:0] window_next;
  logic [CNT_W-1:0]         fill;
  logic [CNT_W-1:0]         fill_next;

  logic [MAX_WORD-1:0][7:0] pat;
  logic [MAX_WORD-1:0][7:0] rep;
  logic [MAX_WORD-1:0][7:0] win_new;
  logic [CNT_W-1:0]         plen;
  logic [CNT_W-1:0]         rlen;
  logic [CNT_W-1:0]         pos;
  logic [CNT_W-1:0]         fill1;
  logic                     full;
  logic                     match;
  logic                     has_cmd;
  logic                     accept;
  logic                     len_write;

  assign text.ready = !qstat.full;
  assign cfg.ready  = 1'b1;
  assign accept     = text.valid && text.ready;
  assign push       = accept && has_cmd;
  assign len_write  = cfg.valid && cfg.ready && (cfg.index == REG_PATTERN_LENGTH);

  always_comb begin
    plen  = clamp_len(pattern_length);
    rlen  = clamp_len(replacement_length);
    pat   = {pattern_high, pattern_low};
    rep   = {replacement_high, replacement_low};
    pos   = (fill >= plen) ? '0 : fill;
    fill1 = pos + CNT_W'(1);
    full  = (fill1 == plen);
    for (int i = 0; i < MAX_WORD; i++) begin
      win_new[i] = (CNT_W'(i) == pos) ? text.text_byte : window[i];
    end
    // The window compare is fully parallel; bytes past the pattern length are ignored.
    match = full;
    for (int i = 0; i < MAX_WORD; i++) begin
      if ((CNT_W'(i) < plen) && (win_new[i] != pat[i])) begin
        match = 1'b0;
      end
    end

    cmd.last = text.text_end;
    if (match) begin
      cmd.bytes   = rep;
      cmd.count   = rlen;
      has_cmd     = 1'b1;
      fill_next   = '0;
      window_next = win_new;
    end else if (full) begin
      // Oldest byte leaves; on the final byte the whole window goes out with it.
      cmd.bytes   = win_new;
      cmd.count   = text.text_end ? plen : CNT_W'(1);
      has_cmd     = 1'b1;
      fill_next   = text.text_end ? '0 : plen - CNT_W'(1);
      window_next = win_new >> 8;
    end else begin
      cmd.bytes   = win_new;
      cmd.count   = fill1;
      has_cmd     = text.text_end;
      fill_next   = text.text_end ? '0 : fill1;
      window_next = win_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill               <= '0;
      pattern_low        <= '0;
      pattern_high       <= '0;
      pattern_length     <= 5'd1;
      replacement_low    <= '0;
      replacement_high   <= '0;
      replacement_length <= 5'd1;
    end else begin
      // A new pattern length empties the window.
      if (len_write) begin
        fill <= '0;
      end else if (accept) begin
        fill <= fill_next;
      end
      if (cfg.valid && cfg.ready) begin
        unique case (cfg.index)
          REG_PATTERN_LOW:        pattern_low <= cfg.data;
          REG_PATTERN_HIGH:       pattern_high <= cfg.data;
          REG_PATTERN_LENGTH:     pattern_length <= cfg.data[4:0];
          REG_REPLACEMENT_LOW:    replacement_low <= cfg.data;
          REG_REPLACEMENT_HIGH:   replacement_high <= cfg.data;
          REG_REPLACEMENT_LENGTH: replacement_length <= cfg.data[4:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      window <= window_next;
    end
  end

endmodule

@@ hw/rtl/swr_queue.sv @@
// Small command queue between the front end and the output sequencer.
module swr_queue (
  input  logic               clk,
  input  logic               rst,
  input  swr_pkg::cmd_t      wr_cmd,
  input  logic               push,
  input  logic               pop,
  output swr_pkg::cmd_t      head,
  output swr_pkg::queue_stat_t qstat
);
  import swr_pkg::*;

  cmd_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   used;

  assign head        = entries[rd_ptr];
  assign qstat.full  = (used == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign qstat.empty = (used == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      used   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        used <= used + (QPTR_W + 1)'(1);
      end else if (pop && !push) begin
        used <= used - (QPTR_W + 1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_cmd;
    end
  end

endmodule

@@ hw/rtl/swr_back.sv @@
// Back end: walks the head command one byte per cycle into the output register while the result side is not stalled.
module swr_back (
  input  logic                 clk,
  input  logic                 rst,
  input  swr_pkg::cmd_t        head,
  input  swr_pkg::queue_stat_t qstat,
  output logic                 pop,
  swr_out_if.source            result
);
  import swr_pkg::*;

  logic [IDX_W-1:0] idx;
  logic             load;
  logic             last_byte;

  assign load      = !qstat.empty && (!result.valid || result.ready);
  assign last_byte = ((CNT_W'(idx) + CNT_W'(1)) == head.count);
  assign pop       = load && last_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
      idx          <= '0;
    end else begin
      if (load) begin
        result.valid <= 1'b1;
        idx          <= last_byte ? '0 : idx + IDX_W'(1);
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result.out_byte <= head.bytes[idx];
      result.out_end  <= head.last && last_byte;
    end
  end

endmodule

@@ tb/tb_stream_word_replace.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the streaming find-and-replace block.
module tb_stream_word_replace;
  import swr_pkg::*;

  localparam logic [2:0] REG_SPARE_A = 3'd6;
  localparam logic [2:0] REG_SPARE_B = 3'd7;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_CYCLES  = 20;
  localparam int HOLD_CYCLES   = 80;
  localparam int STALL_LIMIT   = 3000;
  localparam int TEXT_ITEMS    = 170;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } text_out_t;

  typedef enum bit {ROW_TEXT, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e  kind;
    logic [2:0] idx;
    logic [63:0] data;
    logic [7:0] ch;
    logic       fin;
    logic       typed;
    logic [7:0] want_ch;
    logic       want_last;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst;

  swr_text_if text_ch();
  swr_out_if  result_ch();
  swr_cfg_if  cfg_ch();

  stream_word_replace uut (
    .clk    (clk),
    .rst    (rst),
    .text   (text_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mirror of the block's registers and match window.
  logic [63:0] pat_lo, pat_hi, rep_lo, rep_hi;
  logic [4:0]  pat_len, rep_len;
  logic [7:0]  win_q [MAX_WORD];
  int unsigned win_fill;

  text_out_t rewritten_q[$];
  int fault_count = 0;
  int text_count = 0;
  bit tx_idle = 1'b1;
  bit rx_idle = 1'b1;
  bit hold_req = 1'b0;
  int stall_cycles = 0;

  function automatic int unsigned eff_len(input logic [4:0] len);
    if (len == 5'd0) return 1;
    if (len > 5'(MAX_WORD)) return MAX_WORD;
    return int'(len);
  endfunction

  function automatic logic [7:0] word_at(input logic [63:0] lo, input logic [63:0] hi,
                                         input int unsigned k);
    logic [127:0] w;
    w = {hi, lo};
    return w[8*k +: 8];
  endfunction

  function automatic void apply_reg(input logic [2:0] idx, input logic [63:0] d);
    case (idx)
      REG_PATTERN_LOW: pat_lo = d;
      REG_PATTERN_HIGH: pat_hi = d;
      REG_PATTERN_LENGTH: begin
        pat_len = d[4:0];
        win_fill = 0;
      end
      REG_REPLACEMENT_LOW: rep_lo = d;
      REG_REPLACEMENT_HIGH: rep_hi = d;
      REG_REPLACEMENT_LENGTH: rep_len = d[4:0];
      default: ;
    endcase
  endfunction

  // Works out the bytes that one accepted text byte releases.
  function automatic void predict_rewrite(input logic [7:0] b, input logic fin,
                                          output text_out_t res[$]);
    int unsigned plen, rlen;
    bit hit;
    text_out_t r;
    res.delete();
    plen = eff_len(pat_len);
    rlen = eff_len(rep_len);
    if (win_fill >= plen) win_fill = 0;
    win_q[win_fill] = b;
    win_fill++;
    if (win_fill == plen) begin
      hit = 1'b1;
      for (int i = 0; i < plen; i++) begin
        if (win_q[i] != word_at(pat_lo, pat_hi, i)) hit = 1'b0;
      end
      if (hit) begin
        for (int i = 0; i < rlen; i++) begin
          r.ch = word_at(rep_lo, rep_hi, i);
          r.last = 1'b0;
          res.push_back(r);
        end
        win_fill = 0;
      end else begin
        r.ch = win_q[0];
        r.last = 1'b0;
        res.push_back(r);
        for (int i = 1; i < plen; i++) win_q[i-1] = win_q[i];
        win_fill = plen - 1;
      end
    end
    if (fin) begin
      for (int i = 0; i < win_fill; i++) begin
        r.ch = win_q[i];
        r.last = 1'b0;
        res.push_back(r);
      end
      win_fill = 0;
      if (res.size() > 0) res[res.size()-1].last = 1'b1;
    end
  endfunction

  task automatic drive_text(input logic [7:0] b, input logic fin, input logic typed,
                            input text_out_t typed_res);
    int gap;
    text_out_t got[$];
    gap = tx_idle ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      text_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    text_ch.valid <= 1'b1;
    text_ch.text_byte <= b;
    text_ch.text_end <= fin;
    do @(posedge clk); while (!text_ch.ready);
    text_count++;
    predict_rewrite(b, fin, got);
    if (typed) begin
      rewritten_q.push_back(typed_res);
    end else begin
      foreach (got[i]) rewritten_q.push_back(got[i]);
    end
  endtask

  task automatic wait_idle();
    text_ch.valid <= 1'b0;
    while (rewritten_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] d);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= d;
    do @(posedge clk); while (!cfg_ch.ready);
    apply_reg(idx, d);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_result(input logic [7:0] got_ch, input logic got_last);
    text_out_t want;
    if (rewritten_q.size() == 0) begin
      fault_count++;
      if (fault_count <= 10)
        $display("unexpected output: byte %h end %b", got_ch, got_last);
    end else begin
      want = rewritten_q.pop_front();
      if (want.ch !== got_ch || want.last !== got_last) begin
        fault_count++;
        if (fault_count <= 10)
          $display("output mismatch: expected byte %h end %b, got byte %h end %b",
                   want.ch, want.last, got_ch, got_last);
      end
    end
  endtask

  function automatic stim_row_t row_text(input logic [7:0] b, input logic fin);
    stim_row_t r;
    r = '0;
    r.kind = ROW_TEXT;
    r.ch = b;
    r.fin = fin;
    return r;
  endfunction

  function automatic stim_row_t row_typed(input logic [7:0] b, input logic fin,
                                          input logic [7:0] wb, input logic wl);
    stim_row_t r;
    r = row_text(b, fin);
    r.typed = 1'b1;
    r.want_ch = wb;
    r.want_last = wl;
    return r;
  endfunction

  function automatic stim_row_t row_cfg(input logic [2:0] idx, input logic [63:0] d);
    stim_row_t r;
    r = '0;
    r.kind = ROW_CFG;
    r.idx = idx;
    r.data = d;
    return r;
  endfunction

  function automatic logic [4:0] pick_len();
    case ($urandom_range(0, 9))
      0: return 5'd0;
      1: return 5'd16;
      2: return 5'($urandom_range(17, 31));
      default: return 5'($urandom_range(1, 6));
    endcase
  endfunction

  // Result side: random back-pressure, plus one long hold when asked for.
  initial begin
    int gap;
    result_ch.ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        result_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      gap = rx_idle ? $urandom_range(0, 4) : 0;
      if (gap > 0) begin
        result_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      result_ch.ready <= 1'b1;
      do @(posedge clk); while (!result_ch.valid);
      check_result(result_ch.out_byte, result_ch.out_end);
    end
  end

  always @(posedge clk) begin
    if ((text_ch.valid && text_ch.ready) || (result_ch.valid && result_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  initial begin
    stim_row_t directed_rows[$];
    stim_row_t row;
    text_out_t typed_res;
    logic [7:0] phase_text[$];
    logic [7:0] letters[3];
    logic [63:0] d;
    logic [4:0] plen_pick, rlen_pick;
    int unsigned plen;
    int n, phase_no, r;
    bit wide_bytes, close_text;
    logic fin;

    rst = 1'b1;
    text_ch.valid = 1'b0;
    text_ch.text_byte = 8'h00;
    text_ch.text_end = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_PATTERN_LOW;
    cfg_ch.data = 64'd0;
    pat_lo = 64'd0;
    pat_hi = 64'd0;
    rep_lo = 64'd0;
    rep_hi = 64'd0;
    pat_len = 5'd1;
    rep_len = 5'd1;
    win_fill = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // After reset the pattern and replacement are a single zero byte.
    directed_rows.push_back(row_typed(8'h00, 1'b0, 8'h00, 1'b0));
    directed_rows.push_back(row_typed(8'hFF, 1'b1, 8'hFF, 1'b1));
    // Longest words; a length above the maximum acts as the maximum.
    directed_rows.push_back(row_cfg(REG_PATTERN_LOW, 64'h7F80_FF00_0102_0408));
    directed_rows.push_back(row_cfg(REG_PATTERN_HIGH, 64'h1020_40C3_3CA5_5AE7));
    directed_rows.push_back(row_cfg(REG_PATTERN_LENGTH, 64'd16));
    directed_rows.push_back(row_cfg(REG_REPLACEMENT_LOW, 64'hFFFF_FFFF_FFFF_FFFF));
    directed_rows.push_back(row_cfg(REG_REPLACEMENT_HIGH, 64'h0123_4567_89AB_CDEF));
    directed_rows.push_back(row_cfg(REG_REPLACEMENT_LENGTH, 64'hFFFF_FFFF_FFFF_FFFF));
    directed_rows.push_back(row_cfg(REG_SPARE_A, 64'hFFFF_FFFF_FFFF_FFFF));
    for (int k = 0; k < MAX_WORD; k++)
      directed_rows.push_back(row_text(word_at(64'h7F80_FF00_0102_0408,
                                               64'h1020_40C3_3CA5_5AE7, k), k == 15));
    // Three-byte word with a partial match first; a zero length acts as one.
    directed_rows.push_back(row_cfg(REG_PATTERN_LOW, 64'h0000_0000_0063_6261));
    directed_rows.push_back(row_cfg(REG_PATTERN_LENGTH, 64'd3));
    directed_rows.push_back(row_cfg(REG_REPLACEMENT_LOW, 64'h0000_0000_0000_0058));
    directed_rows.push_back(row_cfg(REG_REPLACEMENT_LENGTH, 64'd0));
    directed_rows.push_back(row_cfg(REG_SPARE_B, 64'h5555_AAAA_5555_AAAA));
    directed_rows.push_back(row_text(8'h61, 1'b0));
    directed_rows.push_back(row_text(8'h62, 1'b0));
    directed_rows.push_back(row_text(8'h61, 1'b0));
    directed_rows.push_back(row_text(8'h62, 1'b0));
    directed_rows.push_back(row_text(8'h63, 1'b0));
    directed_rows.push_back(row_text(8'h78, 1'b0));
    directed_rows.push_back(row_text(8'h79, 1'b0));
    // Changing the pattern length mid-text throws away the two held bytes.
    directed_rows.push_back(row_cfg(REG_PATTERN_LENGTH, 64'hFFFF_FFFF_FFFF_FFE2));
    directed_rows.push_back(row_typed(8'h63, 1'b1, 8'h63, 1'b1));

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.kind == ROW_CFG) begin
        wait_idle();
        write_reg(row.idx, row.data);
      end else begin
        typed_res.ch = row.want_ch;
        typed_res.last = row.want_last;
        drive_text(row.ch, row.fin, row.typed, typed_res);
      end
    end

    typed_res = '0;
    phase_no = 0;
    while (text_count < TEXT_ITEMS) begin
      wait_idle();
      tx_idle = ($urandom_range(0, 3) != 0);
      rx_idle = ($urandom_range(0, 3) != 0);
      wide_bytes = $urandom_range(0, 1);
      foreach (letters[k]) letters[k] = 8'($urandom_range(0, 255));

      for (int w = 0; w < 4; w++) begin
        d = {$urandom, $urandom};
        if (!wide_bytes)
          for (int k = 0; k < 8; k++) d[8*k +: 8] = letters[$urandom_range(0, 2)];
        case (w)
          0: write_reg(REG_PATTERN_LOW, d);
          1: write_reg(REG_PATTERN_HIGH, d);
          2: write_reg(REG_REPLACEMENT_LOW, d);
          default: write_reg(REG_REPLACEMENT_HIGH, d);
        endcase
      end
      plen_pick = pick_len();
      rlen_pick = pick_len();
      d = {$urandom, $urandom};
      d[4:0] = plen_pick;
      write_reg(REG_PATTERN_LENGTH, d);
      d = {$urandom, $urandom};
      d[4:0] = rlen_pick;
      write_reg(REG_REPLACEMENT_LENGTH, d);
      if ($urandom_range(0, 3) == 0)
        write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, {$urandom, $urandom});

      // Mostly copies of the word, some damaged, mixed with its own letters and noise.
      plen = eff_len(pat_len);
      n = (phase_no == 1) ? 32 : $urandom_range(3, 24);
      phase_text.delete();
      while (phase_text.size() < n) begin
        r = $urandom_range(0, 9);
        if (r < 4) begin
          for (int k = 0; k < plen; k++) phase_text.push_back(word_at(pat_lo, pat_hi, k));
          if ($urandom_range(0, 3) == 0)
            phase_text[phase_text.size()-1] ^= 8'(1 << $urandom_range(0, 7));
        end else if (r < 8) begin
          phase_text.push_back(word_at(pat_lo, pat_hi, $urandom_range(0, plen - 1)));
        end else begin
          phase_text.push_back(8'($urandom_range(0, 255)));
        end
      end

      // One phase keeps the sender busy while the result side holds off for long.
      if (phase_no == 1) begin
        tx_idle = 1'b0;
        hold_req = 1'b1;
      end
      close_text = ($urandom_range(0, 3) != 0);
      foreach (phase_text[i]) begin
        fin = ((i == phase_text.size() - 1) && close_text) || ($urandom_range(0, 19) == 0);
        drive_text(phase_text[i], fin, 1'b0, typed_res);
      end
      phase_no++;
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fault_count == 0 && rewritten_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
